// File: rtl/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // internal component precision (Q2.14)
  localparam int COMP_W       = 16;
  localparam int SUM_W        = 34;
  localparam int CIN_W        = 35;
  localparam int CORDIC_W     = 48;
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_MSB     = 40;
  localparam int TURN_W       = 32;
  localparam int ROOT_W       = 32;
  localparam int RAD_W        = 64;
  localparam int ISQRT_STEPS  = 32;

  localparam int LANES      = 3;
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_ROLL  = 2;

  localparam logic [TURN_W-1:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic signed [TURN_W-1:0] QUARTER_TURN = 32'sh4000_0000;

  typedef struct packed {
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic                    zero;
  } isq_side_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
    logic [TURN_W-1:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/q2e_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module q2e_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [q2e_pkg::RAD_W-1:0]      rad_i,
  input  q2e_pkg::isq_side_t             side_i,
  output logic                           valid_o,
  output logic [q2e_pkg::ROOT_W-1:0]     root_o,
  output q2e_pkg::isq_side_t             side_o
);

  localparam int N = q2e_pkg::ISQRT_STEPS;
  localparam int W = q2e_pkg::RAD_W;

  logic [W-1:0]       v_q    [N];
  logic [W-1:0]       r_q    [N];
  q2e_pkg::isq_side_t side_q [N];
  logic [N-1:0]       vld_q;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [W-1:0] Bit = W'(1) << (W - 2 - 2 * i);
    logic [W-1:0]       v_in;
    logic [W-1:0]       r_in;
    logic [W-1:0]       trial;
    q2e_pkg::isq_side_t side_in;
    logic               vld_in;

    if (i == 0) begin : g_first
      assign v_in    = rad_i;
      assign r_in    = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign r_in    = r_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign trial = r_in + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_in;
        if (v_in >= trial) begin
          v_q[i] <= v_in - trial;
          r_q[i] <= (r_in >> 1) + Bit;
        end else begin
          v_q[i] <= v_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = r_q[N-1][q2e_pkg::ROOT_W-1:0];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

// File: rtl/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Vectoring CORDIC, several lanes in lockstep: two prep stages (half-plane fold,
// normalize) followed by one register stage per micro-rotation.
module q2e_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               zero_i,
  input  logic signed [q2e_pkg::CIN_W-1:0]   x_i     [q2e_pkg::LANES],
  input  logic signed [q2e_pkg::CIN_W-1:0]   y_i     [q2e_pkg::LANES],
  output logic                               valid_o,
  output logic                               zero_o,
  output logic [q2e_pkg::TURN_W-1:0]         angle_o [q2e_pkg::LANES]
);

  localparam int N  = q2e_pkg::CORDIC_STEPS;
  localparam int L  = q2e_pkg::LANES;
  localparam int CW = q2e_pkg::CORDIC_W;
  localparam int FW = q2e_pkg::CIN_W + 1;
  localparam int TW = q2e_pkg::TURN_W;
  localparam int SW = $clog2(q2e_pkg::NORM_MSB + 1);

  // prep 1: fold into right half plane
  logic signed [FW-1:0] xf_q   [L];
  logic signed [FW-1:0] yf_q   [L];
  logic [FW-1:0]        mag_q  [L];
  logic [TW-1:0]        zf_q   [L];
  logic [L-1:0]         degf_q;
  logic                 zerof_q;
  logic                 vf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zerof_q <= zero_i;
      for (int l = 0; l < L; l++) begin
        logic signed [FW-1:0] xe;
        logic signed [FW-1:0] ye;
        logic signed [FW-1:0] xn;
        logic signed [FW-1:0] yn;
        xe = FW'(x_i[l]);
        ye = FW'(y_i[l]);
        if (xe < 0) begin
          xn = -xe;
          yn = -ye;
          zf_q[l] <= q2e_pkg::HALF_TURN;
        end else begin
          xn = xe;
          yn = ye;
          zf_q[l] <= '0;
        end
        xf_q[l]   <= xn;
        yf_q[l]   <= yn;
        mag_q[l]  <= $unsigned(xn) | ((yn < 0) ? $unsigned(-yn) : $unsigned(yn));
        degf_q[l] <= (xe == '0) && (ye == '0);
      end
    end
  end

  // prep 2: scale up so the larger magnitude reaches 2^NORM_MSB
  logic signed [CW-1:0] x0_q   [L];
  logic signed [CW-1:0] y0_q   [L];
  logic [TW-1:0]        z0_q   [L];
  logic [L-1:0]         deg0_q;
  logic                 zero0_q;
  logic                 v0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero0_q <= zerof_q;
      deg0_q  <= degf_q;
      for (int l = 0; l < L; l++) begin
        logic [SW-1:0] msb;
        logic [SW-1:0] sh;
        msb = '0;
        for (int b = 0; b < FW; b++) begin
          if (mag_q[l][b]) msb = SW'(b);
        end
        sh = SW'(q2e_pkg::NORM_MSB) - msb;
        x0_q[l] <= CW'(xf_q[l]) <<< sh;
        y0_q[l] <= CW'(yf_q[l]) <<< sh;
        z0_q[l] <= zf_q[l];
      end
    end
  end

  // micro-rotations
  logic signed [CW-1:0] xs_q  [N][L];
  logic signed [CW-1:0] ys_q  [N][L];
  logic [TW-1:0]        zs_q  [N][L];
  logic [L-1:0]         deg_q [N];
  logic [N-1:0]         zero_q;
  logic [N-1:0]         vld_q;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] x_in [L];
    logic signed [CW-1:0] y_in [L];
    logic [TW-1:0]        z_in [L];
    logic [L-1:0]         deg_in;
    logic                 zero_in;
    logic                 vld_in;

    if (i == 0) begin : g_first
      assign x_in    = x0_q;
      assign y_in    = y0_q;
      assign z_in    = z0_q;
      assign deg_in  = deg0_q;
      assign zero_in = zero0_q;
      assign vld_in  = v0_q;
    end else begin : g_next
      assign x_in    = xs_q[i-1];
      assign y_in    = ys_q[i-1];
      assign z_in    = zs_q[i-1];
      assign deg_in  = deg_q[i-1];
      assign zero_in = zero_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        deg_q[i]  <= deg_in;
        zero_q[i] <= zero_in;
        for (int l = 0; l < L; l++) begin
          if (y_in[l] > 0) begin
            xs_q[i][l] <= x_in[l] + (y_in[l] >>> i);
            ys_q[i][l] <= y_in[l] - (x_in[l] >>> i);
            zs_q[i][l] <= z_in[l] + q2e_pkg::atan_turn(i);
          end else begin
            xs_q[i][l] <= x_in[l] - (y_in[l] >>> i);
            ys_q[i][l] <= y_in[l] + (x_in[l] >>> i);
            zs_q[i][l] <= z_in[l] - q2e_pkg::atan_turn(i);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      v0_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= valid_i;
      v0_q <= vf_q;
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      angle_o[l] = deg_q[N-1][l] ? '0 : zs_q[N-1][l];
    end
  end

  assign valid_o = vld_q[N-1];
  assign zero_o  = zero_q[N-1];

endmodule
`default_nettype wire

// File: rtl/quaternion_to_euler_yxz_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Quaternion (x, y, z, w) to Y-X-Z Euler angles as binary angles (2^ANGLE_WIDTH per
// turn). Fully pipelined: one quaternion may be accepted every cycle while the
// output is not stalled. Each result passes through 5 front stages (input register,
// products, sums, common shift, the 32x32 multiply), 32 stages of square root for
// the pitch cosine, 32 CORDIC stages and one output register. The
// pipeline moves as a whole; a stalled output holds every stage, so in_ready_o is
// low only while a finished result waits and out_ready_i is low. A zero-length
// quaternion returns all-zero angles with zero_norm_o set.
module quaternion_to_euler_yxz_core #(
  parameter int QUAT_WIDTH  = q2e_pkg::QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH = q2e_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x_i,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y_i,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z_i,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ANGLE_WIDTH-1:0] pitch_angle_o,
  output logic signed [ANGLE_WIDTH-1:0] yaw_angle_o,
  output logic signed [ANGLE_WIDTH-1:0] roll_angle_o,
  output logic                          zero_norm_o
);

  localparam int CPW = q2e_pkg::COMP_W;
  localparam int SUW = q2e_pkg::SUM_W;
  localparam int CIW = q2e_pkg::CIN_W;
  localparam int TW  = q2e_pkg::TURN_W;
  localparam int Sh  = TW - ANGLE_WIDTH;
  localparam logic [TW-1:0] RoundInc = (Sh == 0) ? '0 : (TW'(1) << ((Sh == 0) ? 0 : Sh - 1));

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // input components at 16-bit precision
  logic signed [CPW-1:0] qx, qy, qz, qw;

  if (QUAT_WIDTH >= CPW) begin : g_trunc
    assign qx = quat_x_i[QUAT_WIDTH-1 -: CPW];
    assign qy = quat_y_i[QUAT_WIDTH-1 -: CPW];
    assign qz = quat_z_i[QUAT_WIDTH-1 -: CPW];
    assign qw = quat_w_i[QUAT_WIDTH-1 -: CPW];
  end else begin : g_ext
    assign qx = CPW'(quat_x_i);
    assign qy = CPW'(quat_y_i);
    assign qz = CPW'(quat_z_i);
    assign qw = CPW'(quat_w_i);
  end

  // stage A: input register
  logic signed [CPW-1:0] cx_q, cy_q, cz_q, cw_q;
  logic va_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= qx;
      cy_q <= qy;
      cz_q <= qz;
      cw_q <= qw;
    end
  end

  // stage B: products
  logic signed [31:0] pxx, pyy, pzz, pww, pwx, pyz, pwy, pzx, pwz, pxy;
  logic signed [CPW:0] d_wmx, d_ymz, d_wpx, d_ypz;
  logic signed [33:0]  pa1, pa2, pb1, pb2;

  always_comb begin
    pxx   = cx_q * cx_q;
    pyy   = cy_q * cy_q;
    pzz   = cz_q * cz_q;
    pww   = cw_q * cw_q;
    pwx   = cw_q * cx_q;
    pyz   = cy_q * cz_q;
    pwy   = cw_q * cy_q;
    pzx   = cz_q * cx_q;
    pwz   = cw_q * cz_q;
    pxy   = cx_q * cy_q;
    d_wmx = (CPW + 1)'(cw_q) - (CPW + 1)'(cx_q);
    d_ymz = (CPW + 1)'(cy_q) - (CPW + 1)'(cz_q);
    d_wpx = (CPW + 1)'(cw_q) + (CPW + 1)'(cx_q);
    d_ypz = (CPW + 1)'(cy_q) + (CPW + 1)'(cz_q);
    pa1   = d_wmx * d_wmx;
    pa2   = d_ymz * d_ymz;
    pb1   = d_wpx * d_wpx;
    pb2   = d_ypz * d_ypz;
  end

  logic [30:0]        sq_x_q, sq_y_q, sq_z_q, sq_w_q;
  logic signed [31:0] p_wx_q, p_yz_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q;
  logic [32:0]        sq_a1_q, sq_a2_q, sq_b1_q, sq_b2_q;
  logic vb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q  <= pxx[30:0];
      sq_y_q  <= pyy[30:0];
      sq_z_q  <= pzz[30:0];
      sq_w_q  <= pww[30:0];
      p_wx_q  <= pwx;
      p_yz_q  <= pyz;
      p_wy_q  <= pwy;
      p_zx_q  <= pzx;
      p_wz_q  <= pwz;
      p_xy_q  <= pxy;
      sq_a1_q <= pa1[32:0];
      sq_a2_q <= pa2[32:0];
      sq_b1_q <= pb1[32:0];
      sq_b2_q <= pb2[32:0];
    end
  end

  // stage C: sums
  logic [32:0]        n2;
  logic [31:0]        sum_xy, sum_xz;
  q2e_pkg::isq_side_t side_c_d;
  logic [SUW-1:0]     a_d, b_d;

  always_comb begin
    n2       = 33'(sq_x_q) + 33'(sq_y_q) + 33'(sq_z_q) + 33'(sq_w_q);
    sum_xy   = 32'(sq_x_q) + 32'(sq_y_q);
    sum_xz   = 32'(sq_x_q) + 32'(sq_z_q);
    side_c_d.s    = (SUW'(p_wx_q) + SUW'(p_yz_q)) <<< 1;
    side_c_d.sy   = (SUW'(p_wy_q) - SUW'(p_zx_q)) <<< 1;
    side_c_d.sr   = (SUW'(p_wz_q) - SUW'(p_xy_q)) <<< 1;
    side_c_d.cy   = $signed({1'b0, n2}) - $signed({1'b0, sum_xy, 1'b0});
    side_c_d.cr   = $signed({1'b0, n2}) - $signed({1'b0, sum_xz, 1'b0});
    side_c_d.zero = (n2 == '0);
    a_d = SUW'(sq_a1_q) + SUW'(sq_a2_q);
    b_d = SUW'(sq_b1_q) + SUW'(sq_b2_q);
  end

  q2e_pkg::isq_side_t side_c_q;
  logic [SUW-1:0]     a_q, b_q;
  logic vc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_c_q <= side_c_d;
      a_q      <= a_d;
      b_q      <= b_d;
    end
  end

  // stage D: common right shift keeping both factors below 2^32
  logic [1:0]         k;
  q2e_pkg::isq_side_t side_d_d;
  logic [SUW-1:0]     a_sh, b_sh;

  always_comb begin
    if (a_q[SUW-1:32] == '0 && b_q[SUW-1:32] == '0) begin
      k = 2'd0;
    end else if (!a_q[SUW-1] && !b_q[SUW-1]) begin
      k = 2'd1;
    end else begin
      k = 2'd2;
    end
    side_d_d   = side_c_q;
    side_d_d.s = side_c_q.s >>> k;
    a_sh       = a_q >> k;
    b_sh       = b_q >> k;
  end

  q2e_pkg::isq_side_t side_d_q;
  logic [31:0]        a_k_q, b_k_q;
  logic vd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_d_q <= side_d_d;
      a_k_q    <= a_sh[31:0];
      b_k_q    <= b_sh[31:0];
    end
  end

  // stage E: A*B, whose root is the pitch cosine term
  q2e_pkg::isq_side_t side_e_q;
  logic [q2e_pkg::RAD_W-1:0] prod_q;
  logic ve_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_e_q <= side_d_q;
      prod_q   <= a_k_q * b_k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  logic                       sq_valid;
  logic [q2e_pkg::ROOT_W-1:0] root;
  q2e_pkg::isq_side_t         sq_side;

  q2e_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_q),
    .rad_i   (prod_q),
    .side_i  (side_e_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  logic signed [CIW-1:0] cx_in [q2e_pkg::LANES];
  logic signed [CIW-1:0] cy_in [q2e_pkg::LANES];

  always_comb begin
    cx_in[q2e_pkg::LANE_PITCH] = $signed({3'b000, root});
    cy_in[q2e_pkg::LANE_PITCH] = CIW'(sq_side.s);
    cx_in[q2e_pkg::LANE_YAW]   = CIW'(sq_side.cy);
    cy_in[q2e_pkg::LANE_YAW]   = CIW'(sq_side.sy);
    cx_in[q2e_pkg::LANE_ROLL]  = CIW'(sq_side.cr);
    cy_in[q2e_pkg::LANE_ROLL]  = CIW'(sq_side.sr);
  end

  logic          cor_valid;
  logic          cor_zero;
  logic [TW-1:0] angle [q2e_pkg::LANES];

  q2e_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .zero_i  (sq_side.zero),
    .x_i     (cx_in),
    .y_i     (cy_in),
    .valid_o (cor_valid),
    .zero_o  (cor_zero),
    .angle_o (angle)
  );

  function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic [TW-1:0] t);
    logic [TW-1:0] r;
    r = t + RoundInc;
    return r[TW-1 -: ANGLE_WIDTH];
  endfunction

  // output stage: clamp pitch to a quarter turn, round, zero-length override
  logic signed [TW-1:0] pitch_raw, pitch_clamped;

  always_comb begin
    pitch_raw = $signed(angle[q2e_pkg::LANE_PITCH]);
    if (pitch_raw > q2e_pkg::QUARTER_TURN) begin
      pitch_clamped = q2e_pkg::QUARTER_TURN;
    end else if (pitch_raw < -q2e_pkg::QUARTER_TURN) begin
      pitch_clamped = -q2e_pkg::QUARTER_TURN;
    end else begin
      pitch_clamped = pitch_raw;
    end
  end

  logic [ANGLE_WIDTH-1:0] pitch_q, yaw_q, roll_q;
  logic                   zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= cor_zero;
      if (cor_zero) begin
        pitch_q <= '0;
        yaw_q   <= '0;
        roll_q  <= '0;
      end else begin
        pitch_q <= to_angle($unsigned(pitch_clamped));
        yaw_q   <= to_angle(angle[q2e_pkg::LANE_YAW]);
        roll_q  <= to_angle(angle[q2e_pkg::LANE_ROLL]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cor_valid;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pitch_angle_o = $signed(pitch_q);
  assign yaw_angle_o   = $signed(yaw_q);
  assign roll_angle_o  = $signed(roll_q);
  assign zero_norm_o   = zero_q;

endmodule
`default_nettype wire

// File: rtl/q2e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module q2e_checker #(
  parameter int QUAT_WIDTH  = q2e_pkg::QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH = q2e_pkg::ANGLE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [QUAT_WIDTH-1:0]  quat_x_i,
  input logic signed [QUAT_WIDTH-1:0]  quat_y_i,
  input logic signed [QUAT_WIDTH-1:0]  quat_z_i,
  input logic signed [QUAT_WIDTH-1:0]  quat_w_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [ANGLE_WIDTH-1:0] pitch_angle_o,
  input logic signed [ANGLE_WIDTH-1:0] yaw_angle_o,
  input logic signed [ANGLE_WIDTH-1:0] roll_angle_o,
  input logic                          zero_norm_o
);

  localparam int Quarter = 2 ** (ANGLE_WIDTH - 2);

  a_ready_follows_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stall");

  a_zero_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |->
      pitch_angle_o == '0 && yaw_angle_o == '0 && roll_angle_o == '0)
    else $error("zero-length result with nonzero angle");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_angle_o <= Quarter && pitch_angle_o >= -Quarter)
    else $error("pitch beyond quarter turn");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pitch_angle_o) && $stable(yaw_angle_o) &&
      $stable(roll_angle_o) && $stable(zero_norm_o))
    else $error("stalled result changed");

endmodule

bind quaternion_to_euler_yxz_core q2e_checker #(
  .QUAT_WIDTH  (QUAT_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH)
) u_q2e_checker (.*);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int QW = q2e_pkg::QUAT_WIDTH_DEF;
  localparam int AW = q2e_pkg::ANGLE_WIDTH_DEF;
  localparam int N_RANDOM = 830;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TBL [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic signed [AW-1:0] roll;
    logic                 zero;
  } euler_t;

  class euler_scoreboard;
    euler_t angles_q[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] vector_angle(longint xi, longint yi);
      longint      xv, yv, dx, dy;
      longint      lim;
      logic [31:0] zv;
      xv = xi;
      yv = yi;
      zv = '0;
      lim = 64'sd1 <<< 40;
      if (xv == 0 && yv == 0) return '0;
      if (xv < 0) begin
        xv = -xv;
        yv = -yv;
        zv = 32'h8000_0000;
      end
      while (xv < lim && yv < lim && yv > -lim) begin
        xv = xv * 2;
        yv = yv * 2;
      end
      for (int i = 0; i < 30; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv > 0) begin
          xv = xv + dx;
          yv = yv - dy;
          zv = zv + ATAN_TBL[i];
        end else begin
          xv = xv - dx;
          yv = yv + dy;
          zv = zv - ATAN_TBL[i];
        end
      end
      return zv;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b, rem;
      r = 0;
      rem = v;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [AW-1:0] round_angle(logic [31:0] t);
      logic [31:0] sum;
      sum = t + (32'd1 << (31 - AW));
      return sum[31:32-AW];
    endfunction

    function euler_t predict_angles(logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
                                    logic signed [QW-1:0] qz, logic signed [QW-1:0] qw);
      longint      x, y, z, w, n2, s, a, b, sy, cy, sr, cr, pv;
      longint unsigned prod;
      int          k;
      logic [31:0] pt;
      euler_t      res;
      x = qx; y = qy; z = qz; w = qw;
      n2 = x * x + y * y + z * z + w * w;
      if (n2 == 0) begin
        res = '{pitch: '0, yaw: '0, roll: '0, zero: 1'b1};
        return res;
      end
      s = 2 * (w * x + y * z);
      a = (w - x) * (w - x) + (y - z) * (y - z);
      b = (w + x) * (w + x) + (y + z) * (y + z);
      k = 0;
      while ((a >>> k) >= (64'sd1 <<< 32) || (b >>> k) >= (64'sd1 <<< 32)) k++;
      prod = longint'(unsigned'(a >>> k)) * longint'(unsigned'(b >>> k));
      pt = vector_angle(longint'(int_sqrt(prod)), s >>> k);
      pv = longint'(signed'(pt));
      if (pv > (64'sd1 <<< 30)) pv = 64'sd1 <<< 30;
      if (pv < -(64'sd1 <<< 30)) pv = -(64'sd1 <<< 30);
      pt = pv[31:0];
      sy = 2 * (w * y - z * x);
      cy = n2 - 2 * (x * x + y * y);
      sr = 2 * (w * z - x * y);
      cr = n2 - 2 * (x * x + z * z);
      res.pitch = round_angle(pt);
      res.yaw   = round_angle(vector_angle(cy, sy));
      res.roll  = round_angle(vector_angle(cr, sr));
      res.zero  = 1'b0;
      return res;
    endfunction

    function void note_quat(logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
                            logic signed [QW-1:0] qz, logic signed [QW-1:0] qw);
      angles_q.push_back(predict_angles(qx, qy, qz, qw));
    endfunction

    function void check_angles(euler_t act);
      euler_t exp_a;
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected result pitch=%0d yaw=%0d roll=%0d zero=%0b",
                 $time, act.pitch, act.yaw, act.roll, act.zero);
        errors++;
        return;
      end
      exp_a = angles_q.pop_front();
      if (act.pitch !== exp_a.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch, act.pitch);
        errors++;
      end
      if (act.yaw !== exp_a.yaw) begin
        $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw, act.yaw);
        errors++;
      end
      if (act.roll !== exp_a.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, act.roll);
        errors++;
      end
      if (act.zero !== exp_a.zero) begin
        $display("%0t: zero_norm expected %0b actual %0b", $time, exp_a.zero, act.zero);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [QW-1:0] quat_x_i = '0;
  logic signed [QW-1:0] quat_y_i = '0;
  logic signed [QW-1:0] quat_z_i = '0;
  logic signed [QW-1:0] quat_w_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [AW-1:0] pitch_angle_o, yaw_angle_o, roll_angle_o;
  logic                 zero_norm_o;

  int  send_idle_pct = 30;
  int  recv_idle_pct = 50;
  int  hold_left = 0;
  euler_scoreboard sb = new();

  quaternion_to_euler_yxz_core #(.QUAT_WIDTH(QW), .ANGLE_WIDTH(AW)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .out_valid_o, .out_ready_i,
    .pitch_angle_o, .yaw_angle_o, .roll_angle_o, .zero_norm_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_angles('{pitch: pitch_angle_o, yaw: yaw_angle_o, roll: roll_angle_o,
                        zero: zero_norm_o});
  end

  task automatic send_quat(logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
                           logic signed [QW-1:0] qz, logic signed [QW-1:0] qw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_x_i <= qx;
    quat_y_i <= qy;
    quat_z_i <= qz;
    quat_w_i <= qw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_quat(qx, qy, qz, qw);
  endtask

  task automatic send_random_quat();
    logic signed [QW-1:0] c [4];
    int r, kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0, 1, 2: c[i] = QW'($urandom());
        3:       c[i] = QW'($signed($urandom_range(8)) - 4);
        default: c[i] = QW'($signed($urandom_range(32768)) - 16384);
      endcase
    end
    if (kind == 8) begin
      // near gimbal lock: w = +-x, z = +-y (same sign)
      r = $urandom_range(1);
      c[3] = r ? c[0] : -c[0];
      c[2] = r ? c[1] : -c[1];
    end
    if (kind == 9 && $urandom_range(7) == 0) c = '{0, 0, 0, 0};
    send_quat(c[0], c[1], c[2], c[3]);
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_quat(0, 0, 0, 0);                 // zero length
    send_quat(0, 0, 0, 16384);             // identity
    send_quat(0, 0, 0, -16384);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);             // yaw of a half turn
    send_quat(0, 0, 16384, 0);             // roll of a half turn
    send_quat(0, -16384, 0, 0);
    send_quat(8192, 0, 0, 8192);           // pitch at +quarter turn
    send_quat(-8192, 0, 0, 8192);          // pitch at -quarter turn
    send_quat(8192, 8192, -8192, 8192);
    send_quat(1, 1, 1, 1);                 // yaw and roll undefined
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, 0, 0, 32767);
    send_quat(1, 0, 0, 0);
    send_quat(0, 0, 0, -1);
    send_quat(0, -1, 0, 0);
    send_quat(0, 0, 1, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 30;
      end
      if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;
      end
      send_random_quat();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.angles_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.angles_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
